>>> hw/rtl/sic_pkg.sv
// Package for the string interleave checker: request and result types,
// opcode and step codes, and the microcode table of the evaluation sequencer.
// No dependencies.
`timescale 1ns / 1ps

package sic_pkg;

  // Opcodes of one request.
  localparam logic [1:0] OP_FIRST  = 2'd0;
  localparam logic [1:0] OP_SECOND = 2'd1;
  localparam logic [1:0] OP_TARGET = 2'd2;
  localparam logic [1:0] OP_EVAL   = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_value;
  } in_req_t;

  typedef struct packed {
    logic is_interleaving;
    logic overflowed;
  } out_res_t;

  // Sequencer step addresses.
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] ST_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] ST_READ  = 3'd2;
  localparam logic [STEP_W-1:0] ST_CALC  = 3'd3;
  localparam logic [STEP_W-1:0] ST_EMIT  = 3'd4;

  // Branch conditions that a control word can test.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_EVAL_REQ,
    COND_BAD,
    COND_LAST_CELL,
    COND_OUT_FREE
  } cond_e;

  // One control word: datapath actions plus a two-way branch.
  typedef struct packed {
    logic              accept;   // take requests, perform loads
    logic              clr_idx;  // zero the grid indexes and the result bit
    logic              rd_en;    // read all stores at the current cell
    logic              calc;     // compute the cell and write the reach row
    logic              emit;     // load the result register, clear lengths
    cond_e             cond;
    logic [STEP_W-1:0] next_t;   // next step when the condition holds
    logic [STEP_W-1:0] next_f;   // next step otherwise
  } ucode_t;

  // Microcode table of the evaluation program.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    uw = '{accept: 1'b0, clr_idx: 1'b0, rd_en: 1'b0, calc: 1'b0, emit: 1'b0,
           cond: COND_ALWAYS, next_t: ST_IDLE, next_f: ST_IDLE};
    case (step)
      ST_IDLE: begin
        uw.accept = 1'b1;
        uw.cond   = COND_EVAL_REQ;
        uw.next_t = ST_CHECK;
        uw.next_f = ST_IDLE;
      end
      ST_CHECK: begin
        uw.clr_idx = 1'b1;
        uw.cond    = COND_BAD;
        uw.next_t  = ST_EMIT;
        uw.next_f  = ST_READ;
      end
      ST_READ: begin
        uw.rd_en  = 1'b1;
        uw.cond   = COND_ALWAYS;
        uw.next_t = ST_CALC;
        uw.next_f = ST_CALC;
      end
      ST_CALC: begin
        uw.calc   = 1'b1;
        uw.cond   = COND_LAST_CELL;
        uw.next_t = ST_EMIT;
        uw.next_f = ST_READ;
      end
      ST_EMIT: begin
        uw.emit   = 1'b1;
        uw.cond   = COND_OUT_FREE;
        uw.next_t = ST_IDLE;
        uw.next_f = ST_EMIT;
      end
      default: begin
        uw.cond   = COND_ALWAYS;
        uw.next_t = ST_IDLE;
        uw.next_f = ST_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

>>> hw/rtl/string_interleave_check_core.sv
// Interleave checker: two sources and a target, prefix grid walked by a microcoded
// sequencer over single-ported stores. Depends on sic_pkg.
// Loads are taken only while the sequencer is idle; for an evaluate request the
// grid is walked with one read and one compute step per grid cell, and the result
// is then registered (no grid walk if the lengths disagree or a load overflowed).
// Throughput: one evaluation at a time. Reset clears lengths, flags, sequencer.
`timescale 1ns / 1ps

module string_interleave_check_core
  import sic_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_res_o
);

  localparam int unsigned CW  = $clog2(MAX_LEN + 1);
  localparam int unsigned TCW = $clog2(2 * MAX_LEN + 1);
  localparam int unsigned AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned TAW = $clog2(2 * MAX_LEN);
  localparam int unsigned TCAP = 2 * MAX_LEN;

  // Stores.
  logic [7:0] first_mem  [MAX_LEN];
  logic [7:0] second_mem [MAX_LEN];
  logic [7:0] target_mem [TCAP];
  logic       reach_mem  [MAX_LEN + 1];

  logic [CW-1:0]     n1_q, n2_q;
  logic [TCW-1:0]    nt_q;
  logic              ovf_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CW-1:0]     i_q, j_q;
  logic              left_q, res_q;
  logic [7:0]        a_rd_q, s_rd_q, t_rd_q;
  logic              up_rd_q;
  logic              out_valid_q;
  out_res_t          out_res_q;

  ucode_t          uw;
  logic            take, do_load, is_eval;
  logic            bad, last_cell, out_free, cond_ok;
  logic            cell_val;
  logic [AW-1:0]   a_addr, s_addr;
  logic [TCW-1:0]  t_sum;
  logic [TAW-1:0]  t_addr;

  assign uw         = ucode_rom(step_q);
  assign in_stall_o = !uw.accept;
  assign take       = in_valid_i && uw.accept;
  assign is_eval    = (in_req_i.opcode == OP_EVAL);
  assign do_load    = take && !is_eval;

  // Branch conditions.
  assign bad       = ovf_q || ((TCW'(n1_q) + TCW'(n2_q)) != nt_q);
  assign last_cell = (i_q == n1_q) && (j_q == n2_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:    cond_ok = 1'b1;
      COND_EVAL_REQ:  cond_ok = take && is_eval;
      COND_BAD:       cond_ok = bad;
      COND_LAST_CELL: cond_ok = last_cell;
      COND_OUT_FREE:  cond_ok = out_free;
      default:        cond_ok = 1'b1;
    endcase
    step_d = cond_ok ? uw.next_t : uw.next_f;
  end

  // Sequencer step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Lengths and overflow flag; loads only happen in the idle step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q  <= '0;
      n2_q  <= '0;
      nt_q  <= '0;
      ovf_q <= 1'b0;
    end else if (uw.emit && out_free) begin
      n1_q  <= '0;
      n2_q  <= '0;
      nt_q  <= '0;
      ovf_q <= 1'b0;
    end else if (do_load) begin
      case (in_req_i.opcode)
        OP_FIRST: begin
          if (n1_q < CW'(MAX_LEN)) n1_q <= n1_q + 1'b1;
          else ovf_q <= 1'b1;
        end
        OP_SECOND: begin
          if (n2_q < CW'(MAX_LEN)) n2_q <= n2_q + 1'b1;
          else ovf_q <= 1'b1;
        end
        OP_TARGET: begin
          if (nt_q < TCW'(TCAP)) nt_q <= nt_q + 1'b1;
          else ovf_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Cell addresses for the current grid position.
  assign a_addr = AW'(i_q - 1'b1);
  assign s_addr = AW'(j_q - 1'b1);
  assign t_sum  = TCW'(i_q) + TCW'(j_q) - 1'b1;
  assign t_addr = t_sum[TAW-1:0];

  // Source stores: written on load, read once per cell.
  always_ff @(posedge clk_i) begin
    if (do_load && in_req_i.opcode == OP_FIRST && n1_q < CW'(MAX_LEN)) begin
      first_mem[n1_q[AW-1:0]] <= in_req_i.char_value;
    end
    if (uw.rd_en) begin
      a_rd_q <= first_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load && in_req_i.opcode == OP_SECOND && n2_q < CW'(MAX_LEN)) begin
      second_mem[n2_q[AW-1:0]] <= in_req_i.char_value;
    end
    if (uw.rd_en) begin
      s_rd_q <= second_mem[s_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load && in_req_i.opcode == OP_TARGET && nt_q < TCW'(TCAP)) begin
      target_mem[nt_q[TAW-1:0]] <= in_req_i.char_value;
    end
    if (uw.rd_en) begin
      t_rd_q <= target_mem[t_addr];
    end
  end

  // Reach row: the old flag above is read, the new flag written back.
  always_ff @(posedge clk_i) begin
    if (uw.calc) begin
      reach_mem[j_q] <= cell_val;
    end
    if (uw.rd_en) begin
      up_rd_q <= reach_mem[j_q];
    end
  end

  // Grid recurrence for one cell; the origin cell is always reachable.
  always_comb begin
    if (i_q == '0 && j_q == '0) begin
      cell_val = 1'b1;
    end else begin
      cell_val = ((j_q != '0) && left_q && (s_rd_q == t_rd_q)) ||
                 ((i_q != '0) && up_rd_q && (a_rd_q == t_rd_q));
    end
  end

  // Grid indexes, left neighbor and result bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      left_q <= 1'b0;
      res_q  <= 1'b0;
    end else if (uw.clr_idx) begin
      i_q   <= '0;
      j_q   <= '0;
      res_q <= 1'b0;
    end else if (uw.calc) begin
      left_q <= cell_val;
      res_q  <= cell_val;
      if (j_q == n2_q) begin
        j_q <= '0;
        i_q <= i_q + 1'b1;
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.emit && out_free) begin
      out_res_q.is_interleaving <= res_q;
      out_res_q.overflowed      <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule
